// ===== hdl/ole_pkg.sv =====
// shared constants, codes and the cell control bundle for the ordered list engine
// no dependencies; imported by every other file of the block
`default_nettype none

package ole_pkg;

   // store geometry
   localparam int DEPTH       = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);

   // request field widths
   localparam int OP_W     = 3;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_W-1:0] OP_GET    = 3'd1;
   localparam logic [OP_W-1:0] OP_SET    = 3'd2;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
   localparam logic [OP_W-1:0] OP_POP    = 3'd5;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd6;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd7;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BADIDX = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NULL   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd3;

   // what every cell does this cycle
   localparam logic [1:0] CELL_HOLD  = 2'd0;
   localparam logic [1:0] CELL_WRITE = 2'd1;
   localparam logic [1:0] CELL_UP    = 2'd2;
   localparam logic [1:0] CELL_DOWN  = 2'd3;

   // broadcast to the row of cells
   typedef struct packed {
      logic [1:0]             kind;
      logic [IDX_W-1:0]       index;
      logic [CNT_W-1:0]       limit;
      logic [VALUE_WIDTH-1:0] value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/ordered_list_engine.sv =====
// top level of the ordered list engine: command decode, cell row, result register
// depends on ole_pkg, ole_cell and ole_find
//
//  channel | dir | fields (lowest bit first)
//  req     | in  | tuser: operation[2:0]; tdata: position[5:0], item_value[37:6]
//  rsp     | out | tdata: status[1:0], read_value[33:2], found_index[39:34],
//          |     |        found[40], entry_count[47:41], is_empty[48]
//
// each request passes three steps: accept (cells update, matches captured),
// first-match encode, then the result register holds until taken.
// a new request is taken only once the previous result has been taken.
// reset empties the list at once; stored entries are not cleared.
`default_nettype none

module ordered_list_engine
   import ole_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // position, item_value
   input  wire logic [2:0]  req_tuser,   // operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata    // status, read_value, found_index, found,
                                         // entry_count, is_empty
);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_RESOLVE = 2'd1;
   localparam logic [1:0] S_HOLD    = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [STATUS_W-1:0]    status_ff;
   logic [VALUE_WIDTH-1:0] read_ff;
   logic [DEPTH-1:0]       match_ff;
   logic [55:0]            rsp_data_ff;

   logic [OP_W-1:0]        req_op;
   logic [POS_W-1:0]       req_pos;
   logic [VALUE_WIDTH-1:0] req_val;
   logic                   req_go;
   logic [STATUS_W-1:0]    status_in;
   logic                   search_go;
   logic                   read_go;
   cell_ctrl_type          ctrl;

   logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]       cell_match;
   logic                   find_hit;
   logic [IDX_W-1:0]       find_index;

   logic                   pos_live;
   logic                   pos_room;
   logic                   is_full;
   logic                   is_null;

   assign req_op  = req_tuser;
   assign req_pos = req_tdata[POS_W-1:0];
   assign req_val = req_tdata[POS_W +: VALUE_WIDTH];
   assign req_go  = req_tvalid && req_tready;

   assign pos_live = {1'b0, req_pos} < count_ff;
   assign pos_room = {1'b0, req_pos} <= count_ff;
   assign is_full  = count_ff == CNT_W'(DEPTH);
   assign is_null  = req_val == '0;

   // command decode: status, count update and cell command
   always_comb begin
      status_in  = STAT_OK;
      count_in   = count_ff;
      search_go  = 1'b0;
      read_go    = 1'b0;
      ctrl.kind  = CELL_HOLD;
      ctrl.index = req_pos;
      ctrl.limit = count_ff;
      ctrl.value = req_val;
      case (req_op)
         OP_APPEND: begin
            if (is_null) status_in = STAT_NULL;
            else if (is_full) status_in = STAT_FULL;
            else begin
               ctrl.kind  = CELL_WRITE;
               ctrl.index = count_ff[IDX_W-1:0];
               count_in   = count_ff + 1'b1;
            end
         end
         OP_GET: begin
            if (!pos_live) status_in = STAT_BADIDX;
            else read_go = 1'b1;
         end
         OP_SET: begin
            if (is_null) status_in = STAT_NULL;
            else if (!pos_live) status_in = STAT_BADIDX;
            else ctrl.kind = CELL_WRITE;
         end
         OP_INSERT: begin
            if (is_null) status_in = STAT_NULL;
            else if (!pos_room) status_in = STAT_BADIDX;
            else if (is_full) status_in = STAT_FULL;
            else begin
               ctrl.kind = CELL_UP;
               count_in  = count_ff + 1'b1;
            end
         end
         OP_REMOVE, OP_POP: begin
            if (!pos_live) status_in = STAT_BADIDX;
            else begin
               ctrl.kind = CELL_DOWN;
               read_go   = req_op == OP_POP;
               count_in  = count_ff - 1'b1;
            end
         end
         OP_SEARCH: begin
            if (is_null) status_in = STAT_NULL;
            else search_go = 1'b1;
         end
         default: begin
            count_in = '0;
         end
      endcase
      if (!req_go) begin
         ctrl.kind = CELL_HOLD;
         count_in  = count_ff;
      end
   end

   // row of cells, each fed by its neighbours, with zero past either end
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_v;
      logic [VALUE_WIDTH-1:0] right_v;
      if (g == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = cell_value[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = cell_value[g+1];
      end
      ole_cell u_cell (
         .clock       (clock),
         .cell_index  (IDX_W'(g)),
         .ctrl        (ctrl),
         .left_value  (left_v),
         .right_value (right_v),
         .value_out   (cell_value[g]),
         .match_out   (cell_match[g])
      );
   end

   ole_find u_find (
      .match_vec   (match_ff),
      .found       (find_hit),
      .found_index (find_index)
   );

   // sequencing
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (req_tvalid) state_in = S_RESOLVE;
         S_RESOLVE: state_in = S_HOLD;
         S_HOLD:    if (rsp_tready) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // capture read data and match vector at the accepting edge
   always_ff @(posedge clock) begin
      if (req_go) begin
         status_ff <= status_in;
         read_ff   <= read_go ? cell_value[req_pos] : '0;
         match_ff  <= search_go ? cell_match : '0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (state_ff == S_RESOLVE) begin
         rsp_data_ff <= {7'd0, (count_ff == '0), count_ff, find_hit, find_index,
                         read_ff, status_ff};
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = state_ff == S_HOLD;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond store depth");

   a_accept_resolve: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_RESOLVE && !req_tready)
      else $error("request accepted without moving to resolve");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[40] |-> rsp_tdata[1:0] == STAT_OK)
      else $error("search hit reported with error status");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[48] == (rsp_tdata[47:41] == '0))
      else $error("empty flag disagrees with entry count");

   a_count_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      !(req_tvalid && req_tready) |=> $stable(count_ff))
      else $error("entry count changed without a request");
`endif

endmodule

`default_nettype wire

// ===== hdl/ole_cell.sv =====
// one storage cell of the list: holds one entry, shifts to or from its neighbours
// depends on ole_pkg
`default_nettype none

module ole_cell
   import ole_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic [IDX_W-1:0]       cell_index,
   input  wire cell_ctrl_type          ctrl,
   input  wire logic [VALUE_WIDTH-1:0] left_value,
   input  wire logic [VALUE_WIDTH-1:0] right_value,
   output logic [VALUE_WIDTH-1:0]      value_out,
   output logic                        match_out
);

   logic [VALUE_WIDTH-1:0] entry_ff;
   logic [VALUE_WIDTH-1:0] entry_in;

   // next entry from the broadcast command
   always_comb begin
      entry_in = entry_ff;
      case (ctrl.kind)
         CELL_WRITE: begin
            if (cell_index == ctrl.index) entry_in = ctrl.value;
         end
         CELL_UP: begin
            if (cell_index == ctrl.index) entry_in = ctrl.value;
            else if (cell_index > ctrl.index) entry_in = left_value;
         end
         CELL_DOWN: begin
            if (cell_index >= ctrl.index) entry_in = right_value;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // local compare against the search key, live entries only
   assign match_out = (entry_ff == ctrl.value) &&
                      ({1'b0, cell_index} < ctrl.limit);
   assign value_out = entry_ff;

endmodule

`default_nettype wire

// ===== hdl/ole_find.sv =====
// first-match encoder over the registered match vector of the cell row
// depends on ole_pkg
`default_nettype none

module ole_find
   import ole_pkg::*;
(
   input  wire logic [DEPTH-1:0] match_vec,
   output logic                  found,
   output logic [IDX_W-1:0]      found_index
);

   // lowest set bit wins
   always_comb begin
      found_index = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_vec[i]) found_index = IDX_W'(i);
      end
   end

   assign found = |match_vec;

endmodule

`default_nettype wire

// ===== test/ordered_list_engine_test.sv =====
// self-checking bench for ordered_list_engine: directed table then random command traffic
// depends on ole_pkg and the ordered_list_engine rtl; results checked against a local list model

module ordered_list_engine_test;
   import ole_pkg::*;

   localparam int REQUEST_TARGET = 1400;
   localparam int CALM_FROM      = 1250;
   localparam int SCRIPT_LEN     = 24;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [VALUE_WIDTH-1:0] read_value;
      logic [IDX_W-1:0]       found_index;
      logic                   found;
      logic [6:0]             entry_count;
      logic                   is_empty;
   } list_result_type;

   // one directed row; the result part is only used when pinned is set
   typedef struct packed {
      logic [OP_W-1:0]        op;
      logic [POS_W-1:0]       pos;
      logic [VALUE_WIDTH-1:0] value;
      logic                   pinned;
      logic [STATUS_W-1:0]    status;
      logic [VALUE_WIDTH-1:0] read_value;
      logic [IDX_W-1:0]       found_index;
      logic                   found;
      logic [6:0]             entry_count;
   } script_row_type;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_NOISE} traffic_mode_type;

   localparam script_row_type SCRIPT [0:SCRIPT_LEN-1] = '{
      // empty list: every index is bad, null refused first
      '{OP_GET,    6'd0,  32'h0,        1'b1, STAT_BADIDX, 32'h0,        6'd0, 1'b0, 7'd0},
      '{OP_APPEND, 6'd0,  32'h0,        1'b1, STAT_NULL,   32'h0,        6'd0, 1'b0, 7'd0},
      '{OP_SEARCH, 6'd0,  32'h0,        1'b1, STAT_NULL,   32'h0,        6'd0, 1'b0, 7'd0},
      '{OP_REMOVE, 6'd0,  32'h0,        1'b1, STAT_BADIDX, 32'h0,        6'd0, 1'b0, 7'd0},
      '{OP_POP,    6'd63, 32'h0,        1'b1, STAT_BADIDX, 32'h0,        6'd0, 1'b0, 7'd0},
      '{OP_INSERT, 6'd1,  32'h5,        1'b1, STAT_BADIDX, 32'h0,        6'd0, 1'b0, 7'd0},
      '{OP_CLEAR,  6'd0,  32'h0,        1'b1, STAT_OK,     32'h0,        6'd0, 1'b0, 7'd0},
      // build [1, ffffffff, 80000000] from both ends
      '{OP_APPEND, 6'd0,  32'hFFFFFFFF, 1'b1, STAT_OK,     32'h0,        6'd0, 1'b0, 7'd1},
      '{OP_INSERT, 6'd0,  32'h1,        1'b1, STAT_OK,     32'h0,        6'd0, 1'b0, 7'd2},
      '{OP_INSERT, 6'd2,  32'h80000000, 1'b1, STAT_OK,     32'h0,        6'd0, 1'b0, 7'd3},
      '{OP_GET,    6'd0,  32'h0,        1'b1, STAT_OK,     32'h1,        6'd0, 1'b0, 7'd3},
      '{OP_GET,    6'd2,  32'h0,        1'b1, STAT_OK,     32'h80000000, 6'd0, 1'b0, 7'd3},
      '{OP_SET,    6'd1,  32'hA5A5A5A5, 1'b1, STAT_OK,     32'h0,        6'd0, 1'b0, 7'd3},
      '{OP_SET,    6'd3,  32'h7,        1'b1, STAT_BADIDX, 32'h0,        6'd0, 1'b0, 7'd3},
      '{OP_SET,    6'd0,  32'h0,        1'b1, STAT_NULL,   32'h0,        6'd0, 1'b0, 7'd3},
      '{OP_SEARCH, 6'd0,  32'hA5A5A5A5, 1'b1, STAT_OK,     32'h0,        6'd1, 1'b1, 7'd3},
      // search miss reports index zero
      '{OP_SEARCH, 6'd0,  32'h12345678, 1'b1, STAT_OK,     32'h0,        6'd0, 1'b0, 7'd3},
      // duplicate value, first match wins; then pop and remove shift down
      '{OP_APPEND, 6'd0,  32'h1,        1'b0, STAT_OK,     32'h0,        6'd0, 1'b0, 7'd0},
      '{OP_SEARCH, 6'd0,  32'h1,        1'b0, STAT_OK,     32'h0,        6'd0, 1'b0, 7'd0},
      '{OP_POP,    6'd1,  32'h0,        1'b0, STAT_OK,     32'h0,        6'd0, 1'b0, 7'd0},
      '{OP_REMOVE, 6'd0,  32'h0,        1'b0, STAT_OK,     32'h0,        6'd0, 1'b0, 7'd0},
      '{OP_INSERT, 6'd63, 32'h3,        1'b1, STAT_BADIDX, 32'h0,        6'd0, 1'b0, 7'd2},
      '{OP_GET,    6'd63, 32'h0,        1'b1, STAT_BADIDX, 32'h0,        6'd0, 1'b0, 7'd2},
      '{OP_CLEAR,  6'd0,  32'h0,        1'b1, STAT_OK,     32'h0,        6'd0, 1'b0, 7'd0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // position, item_value
   logic [2:0]  req_tuser  = '0;   // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // status, read_value, found_index, found,
                                   // entry_count, is_empty

   // local copy of the list
   logic [VALUE_WIDTH-1:0] list_store [DEPTH];
   int                     list_len = 0;

   list_result_type awaited_results [$];
   int              mismatch_count = 0;
   int              requests_sent  = 0;
   bit              calm_tail      = 1'b0;
   int              stall_left     = 0;

   ordered_list_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // apply one command to the local list and return the result it should give
   function automatic list_result_type predict_list_command(logic [OP_W-1:0] op,
                                                            logic [POS_W-1:0] pos,
                                                            logic [VALUE_WIDTH-1:0] value);
      list_result_type r;
      int              i;
      r = '0;
      r.status = STAT_OK;
      case (op)
         OP_APPEND: begin
            if (value == '0) r.status = STAT_NULL;
            else if (list_len >= DEPTH) r.status = STAT_FULL;
            else begin
               list_store[list_len] = value;
               list_len++;
            end
         end
         OP_GET: begin
            if (int'(pos) >= list_len) r.status = STAT_BADIDX;
            else r.read_value = list_store[pos];
         end
         OP_SET: begin
            if (value == '0) r.status = STAT_NULL;
            else if (int'(pos) >= list_len) r.status = STAT_BADIDX;
            else list_store[pos] = value;
         end
         OP_INSERT: begin
            if (value == '0) r.status = STAT_NULL;
            else if (int'(pos) > list_len) r.status = STAT_BADIDX;
            else if (list_len >= DEPTH) r.status = STAT_FULL;
            else begin
               for (i = list_len; i > int'(pos); i--) list_store[i] = list_store[i-1];
               list_store[pos] = value;
               list_len++;
            end
         end
         OP_REMOVE, OP_POP: begin
            if (int'(pos) >= list_len) r.status = STAT_BADIDX;
            else begin
               if (op == OP_POP) r.read_value = list_store[pos];
               for (i = int'(pos); i + 1 < list_len; i++) list_store[i] = list_store[i+1];
               list_len--;
            end
         end
         OP_SEARCH: begin
            if (value == '0) r.status = STAT_NULL;
            else begin
               for (i = 0; i < list_len; i++) begin
                  if (!r.found && list_store[i] == value) begin
                     r.found       = 1'b1;
                     r.found_index = i[IDX_W-1:0];
                  end
               end
            end
         end
         default: list_len = 0;
      endcase
      r.entry_count = list_len[6:0];
      r.is_empty    = (list_len == 0);
      return r;
   endfunction

   // hold one request until taken, then record what it should produce
   task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic [VALUE_WIDTH-1:0] value, input bit pinned,
                               input list_result_type pinned_result);
      list_result_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, value, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_list_command(op, pos, value);
      awaited_results.push_back(pinned ? pinned_result : predicted);
      requests_sent++;
      if (requests_sent >= CALM_FROM) calm_tail = 1'b1;
   endtask

   // occasional burst of idle cycles on the request side
   task automatic sender_gap();
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // hold off until every outstanding result has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // choose a command that suits the traffic mode and the current list
   task automatic pick_command(input traffic_mode_type mode, output logic [OP_W-1:0] op,
                               output logic [POS_W-1:0] pos,
                               output logic [VALUE_WIDTH-1:0] value);
      int roll;
      int top;
      roll = $urandom_range(0, 19);
      case (mode)
         MODE_FILL: begin
            if (roll < 9) op = OP_APPEND;
            else if (roll < 16) op = OP_INSERT;
            else if (roll < 17) op = OP_GET;
            else if (roll < 18) op = OP_SET;
            else if (roll < 19) op = OP_SEARCH;
            else op = OP_POP;
         end
         MODE_DRAIN: begin
            if (roll < 7) op = OP_REMOVE;
            else if (roll < 14) op = OP_POP;
            else if (roll < 16) op = OP_GET;
            else if (roll < 18) op = OP_SEARCH;
            else op = OP_APPEND;
         end
         MODE_MIX: begin
            case ($urandom_range(0, 6))
               0: op = OP_APPEND;
               1: op = OP_GET;
               2: op = OP_SET;
               3: op = OP_INSERT;
               4: op = OP_REMOVE;
               5: op = OP_POP;
               default: op = OP_SEARCH;
            endcase
            if ($urandom_range(0, 39) == 0) op = OP_CLEAR;
         end
         default: op = OP_W'($urandom_range(0, 7));
      endcase

      // positions mostly in range, the boundary at the count included
      top = (list_len > 63) ? 63 : list_len;
      if (mode == MODE_NOISE || $urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 63));
      else pos = POS_W'($urandom_range(0, top));

      // null, existing value, small value for duplicates, or any word
      roll = $urandom_range(0, 15);
      if (roll < 2) value = '0;
      else if (roll < 7 && list_len > 0) value = list_store[$urandom_range(0, list_len - 1)];
      else if (roll < 9) value = VALUE_WIDTH'($urandom_range(1, 4));
      else value = $urandom;
   endtask

   task automatic check_field(input string name, input longint unsigned expected,
                              input longint unsigned actual);
      if (expected != actual) begin
         $error("%s: expected %0h, got %0h", name, expected, actual);
         mismatch_count++;
      end
   endtask

   // result side: compare each taken result, then decide the next ready
   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            $error("result: none expected, got %0h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("status", want.status, rsp_tdata[1:0]);
            check_field("read_value", want.read_value, rsp_tdata[33:2]);
            check_field("found_index", want.found_index, rsp_tdata[39:34]);
            check_field("found", want.found, rsp_tdata[40]);
            check_field("entry_count", want.entry_count, rsp_tdata[47:41]);
            check_field("is_empty", want.is_empty, rsp_tdata[48]);
         end
      end
      if (reset || calm_tail) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // request side: directed table, then random traffic in segments
   initial begin
      script_row_type    row;
      list_result_type   pinned_result;
      traffic_mode_type  mode;
      logic [OP_W-1:0]   op;
      logic [POS_W-1:0]  pos;
      logic [VALUE_WIDTH-1:0] value;
      int                seg_len;
      int                segment;
      int                n;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < SCRIPT_LEN; k++) begin
         row                       = SCRIPT[k];
         pinned_result             = '0;
         pinned_result.status      = row.status;
         pinned_result.read_value  = row.read_value;
         pinned_result.found_index = row.found_index;
         pinned_result.found       = row.found;
         pinned_result.entry_count = row.entry_count;
         pinned_result.is_empty    = (row.entry_count == 0);
         send_request(row.op, row.pos, row.value, row.pinned, pinned_result);
         sender_gap();
      end
      wait_for_results();

      segment = 0;
      while (requests_sent < REQUEST_TARGET) begin
         mode = (segment == 0) ? MODE_FILL : traffic_mode_type'($urandom_range(0, 3));
         case (mode)
            MODE_FILL:  seg_len = 100;
            MODE_DRAIN: seg_len = 50;
            MODE_MIX:   seg_len = 40;
            default:    seg_len = 12;
         endcase
         for (n = 0; n < seg_len && requests_sent < REQUEST_TARGET; n++) begin
            pick_command(mode, op, pos, value);
            send_request(op, pos, value, 1'b0, '0);
            sender_gap();
         end
         if (segment % 4 == 3) wait_for_results();
         segment++;
      end

      // drain and let the block settle
      wait_for_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("ordered_list_engine_test: done, clean");
      end else begin
         $display("ordered_list_engine_test: done, errors");
      end
      $finish;
   end

   // hang guard
   initial begin
      #2000000;
      $display("ordered_list_engine_test: done, errors");
      $finish;
   end

endmodule
